/* design/pmpa_pkg.sv */
// Package with widths, sequencer codes and shared types of the point mass accumulator.
package pmpa_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int WEIGHT_WIDTH = 16;
  localparam int MASS_WIDTH   = 32;
  localparam int MOM_WIDTH    = 48;
  localparam int INR_WIDTH    = 64;
  localparam int DIAG_WIDTH   = 63;
  localparam int QUO_WIDTH    = 48;
  localparam int QCNT_WIDTH   = 6;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACCUM = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_OUT   = 3'd3;
  localparam logic [2:0] ST_SQR   = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd6;

  // Control between the top level and the divider.
  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [MOM_WIDTH-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [COORD_WIDTH-1:0] coord;
  } div_rsp_t;

endpackage

/* design/pmpa_divider.sv */
// Restoring divider, one quotient bit per cycle, with centroid saturation.
module pmpa_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmpa_pkg::div_req_t            req,
  input  logic [pmpa_pkg::MASS_WIDTH-1:0] divisor,
  output pmpa_pkg::div_rsp_t            rsp
);
  import pmpa_pkg::*;

  localparam int CMAX = (1 << (COORD_WIDTH - 1)) - 1;

  logic                  busy_r, busy_nxt;
  logic [QCNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [QUO_WIDTH-1:0]  quo_r, quo_nxt;
  logic [MASS_WIDTH:0]   rem_r, rem_nxt;
  logic                  neg_r, neg_nxt;
  logic                  done_r, done_nxt;
  logic [COORD_WIDTH-1:0] coord_r, coord_nxt;
  logic [MASS_WIDTH:0]   trial;
  logic [MASS_WIDTH:0]   shifted;
  logic [QUO_WIDTH-1:0]  qfin;

  // One shift and subtract per cycle.
  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    coord_nxt = coord_r;
    shifted   = {rem_r[MASS_WIDTH-1:0], quo_r[QUO_WIDTH-1]};
    trial     = shifted - {1'b0, divisor};
    qfin      = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QCNT_WIDTH'(QUO_WIDTH);
      quo_nxt  = req.mag;
      rem_nxt  = '0;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      if (!trial[MASS_WIDTH]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[QUO_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[QUO_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == QCNT_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        qfin     = quo_nxt;
        if (divisor == '0) begin
          coord_nxt = '0;
        end else if (neg_r) begin
          if (qfin > QUO_WIDTH'(CMAX + 1)) coord_nxt = COORD_WIDTH'(CMAX + 1);
          else coord_nxt = COORD_WIDTH'(~qfin + 1'b1);
        end else begin
          if (qfin > QUO_WIDTH'(CMAX)) coord_nxt = COORD_WIDTH'(CMAX);
          else coord_nxt = COORD_WIDTH'(qfin);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    coord_r <= coord_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.coord = coord_r;

endmodule

/* design/point_mass_property_accumulator_core.sv */
// Top level of the point mass accumulator: sums, sequencer and result register.
//
// Each beat takes one point and its weight and returns one result beat with the
// running mass, centroid and inertia terms. Each point goes through these steps
// in order: the squared and then the weighted per-point terms are registered,
// the sums are updated, three passes (a start plus a 48-bit quotient) through
// the shared one-bit-per-cycle divider form the centroid coordinates, the last
// quotient is taken, the result is offered until it is not stalled, and the
// idle state takes the next beat. The input is stalled while an item is in work.
// Rejected points (zero weight) also pass through the divider so every result
// has the same latency.
module point_mass_property_accumulator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pmpa_pkg::COORD_WIDTH-1:0] in_px,
  input  logic signed [pmpa_pkg::COORD_WIDTH-1:0] in_py,
  input  logic signed [pmpa_pkg::COORD_WIDTH-1:0] in_pz,
  input  logic [pmpa_pkg::WEIGHT_WIDTH-1:0]     in_weight,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_error,
  output logic [pmpa_pkg::MASS_WIDTH-1:0]       out_total_mass,
  output logic signed [pmpa_pkg::COORD_WIDTH-1:0] out_cx,
  output logic signed [pmpa_pkg::COORD_WIDTH-1:0] out_cy,
  output logic signed [pmpa_pkg::COORD_WIDTH-1:0] out_cz,
  output logic [pmpa_pkg::DIAG_WIDTH-1:0]       out_ixx,
  output logic [pmpa_pkg::DIAG_WIDTH-1:0]       out_iyy,
  output logic [pmpa_pkg::DIAG_WIDTH-1:0]       out_izz,
  output logic signed [pmpa_pkg::INR_WIDTH-1:0] out_ixy,
  output logic signed [pmpa_pkg::INR_WIDTH-1:0] out_ixz,
  output logic signed [pmpa_pkg::INR_WIDTH-1:0] out_iyz
);
  import pmpa_pkg::*;

  localparam int SQ_WIDTH = 2 * COORD_WIDTH;
  localparam int PW       = SQ_WIDTH + 1 + WEIGHT_WIDTH;

  logic [2:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  logic [MASS_WIDTH-1:0]        mass_r;
  logic signed [MOM_WIDTH-1:0]  mom_r [3];
  logic [DIAG_WIDTH-1:0]        diag_r [3];
  logic signed [INR_WIDTH-1:0]  off_r [3];

  logic signed [COORD_WIDTH-1:0]  px_r, py_r, pz_r;
  logic [WEIGHT_WIDTH-1:0]        w_r;
  logic                           rst_r, err_r;
  logic [COORD_WIDTH-1:0]         c_r [3];

  div_req_t req;
  div_rsp_t rsp;

  // Point captured on accept.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      px_r  <= in_px;
      py_r  <= in_py;
      pz_r  <= in_pz;
      w_r   <= in_weight;
      rst_r <= in_restart;
      err_r <= (in_weight == '0);
    end
  end

  // Per-point terms are registered in order: squares first, then the weight products.
  logic [COORD_WIDTH-1:0] ax, ay, az;
  logic [SQ_WIDTH-1:0]    sqx, sqy, sqz, pxy, pxz, pyz;
  logic [SQ_WIDTH:0]      sqs [3];
  logic [SQ_WIDTH:0]      sqs_r [3];
  logic [SQ_WIDTH-1:0]    crs_r [3];
  logic [PW-1:0]          tdiag [3];
  logic [PW-1:0]          toff [3];
  logic [PW-1:0]          tdiag_r [3];
  logic [PW-1:0]          toff_r [3];
  logic                   noff [3];
  logic signed [COORD_WIDTH+WEIGHT_WIDTH:0] tmom [3];
  logic signed [COORD_WIDTH+WEIGHT_WIDTH:0] tmom_r [3];

  always_comb begin
    ax  = px_r[COORD_WIDTH-1] ? COORD_WIDTH'(-px_r) : COORD_WIDTH'(px_r);
    ay  = py_r[COORD_WIDTH-1] ? COORD_WIDTH'(-py_r) : COORD_WIDTH'(py_r);
    az  = pz_r[COORD_WIDTH-1] ? COORD_WIDTH'(-pz_r) : COORD_WIDTH'(pz_r);
    sqx = ax * ax;
    sqy = ay * ay;
    sqz = az * az;
    pxy = ax * ay;
    pxz = ax * az;
    pyz = ay * az;
    sqs[0] = {1'b0, sqy} + {1'b0, sqz};
    sqs[1] = {1'b0, sqx} + {1'b0, sqz};
    sqs[2] = {1'b0, sqx} + {1'b0, sqy};
    for (int i = 0; i < 3; i++) begin
      tdiag[i] = PW'(sqs_r[i]) * PW'(w_r);
      toff[i]  = PW'(crs_r[i]) * PW'(w_r);
    end
    noff[0]  = (px_r[COORD_WIDTH-1] == py_r[COORD_WIDTH-1]);
    noff[1]  = (px_r[COORD_WIDTH-1] == pz_r[COORD_WIDTH-1]);
    noff[2]  = (py_r[COORD_WIDTH-1] == pz_r[COORD_WIDTH-1]);
    tmom[0]  = $signed({1'b0, w_r}) * px_r;
    tmom[1]  = $signed({1'b0, w_r}) * py_r;
    tmom[2]  = $signed({1'b0, w_r}) * pz_r;
  end

  // Term registers; products are at most 33 by 16 bits.
  always_ff @(posedge clk) begin
    if (state_r == ST_SQR) begin
      for (int i = 0; i < 3; i++) sqs_r[i] <= sqs[i];
      crs_r[0] <= pxy;
      crs_r[1] <= pxz;
      crs_r[2] <= pyz;
    end
    if (state_r == ST_MUL) begin
      for (int i = 0; i < 3; i++) begin
        tdiag_r[i] <= tdiag[i];
        toff_r[i]  <= toff[i];
        tmom_r[i]  <= tmom[i];
      end
    end
  end

  // Saturating accumulation in the accumulate state; terms are far below the sum widths.
  logic [MASS_WIDTH:0]          msum;
  logic signed [MOM_WIDTH:0]    mbase [3];
  logic signed [MOM_WIDTH:0]    msm [3];
  logic [DIAG_WIDTH:0]          dsum [3];
  logic signed [INR_WIDTH:0]    osum [3];
  logic [MASS_WIDTH-1:0]        mbase_m;
  logic [DIAG_WIDTH-1:0]        dbase [3];
  logic signed [INR_WIDTH-1:0]  obase [3];

  always_comb begin
    mbase_m = rst_r ? '0 : mass_r;
    msum    = {1'b0, mbase_m} + (MASS_WIDTH+1)'(w_r);
    for (int i = 0; i < 3; i++) begin
      mbase[i] = rst_r ? '0 : (MOM_WIDTH+1)'(mom_r[i]);
      dbase[i] = rst_r ? '0 : diag_r[i];
      obase[i] = rst_r ? '0 : off_r[i];
      msm[i]   = mbase[i] + (MOM_WIDTH+1)'(tmom_r[i]);
      dsum[i]  = {1'b0, dbase[i]} + (DIAG_WIDTH+1)'(tdiag_r[i]);
      osum[i]  = noff[i] ? (INR_WIDTH+1)'(obase[i]) - (INR_WIDTH+1)'(toff_r[i])
                         : (INR_WIDTH+1)'(obase[i]) + (INR_WIDTH+1)'(toff_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= '0;
      for (int i = 0; i < 3; i++) begin
        mom_r[i]  <= '0;
        diag_r[i] <= '0;
        off_r[i]  <= '0;
      end
    end else if (state_r == ST_ACCUM && !err_r) begin
      mass_r <= msum[MASS_WIDTH] ? '1 : msum[MASS_WIDTH-1:0];
      for (int i = 0; i < 3; i++) begin
        if (msm[i][MOM_WIDTH] != msm[i][MOM_WIDTH-1])
          mom_r[i] <= msm[i][MOM_WIDTH] ? {1'b1, {(MOM_WIDTH-1){1'b0}}}
                                         : {1'b0, {(MOM_WIDTH-1){1'b1}}};
        else
          mom_r[i] <= msm[i][MOM_WIDTH-1:0];
        diag_r[i] <= dsum[i][DIAG_WIDTH] ? '1 : dsum[i][DIAG_WIDTH-1:0];
        if (osum[i][INR_WIDTH] != osum[i][INR_WIDTH-1])
          off_r[i] <= osum[i][INR_WIDTH] ? {1'b1, {(INR_WIDTH-1){1'b0}}}
                                          : {1'b0, {(INR_WIDTH-1){1'b1}}};
        else
          off_r[i] <= osum[i][INR_WIDTH-1:0];
      end
    end
  end

  // Divider request for the current axis, issued once the sums hold the new point.
  logic signed [MOM_WIDTH-1:0] mcur;
  always_comb begin
    case (axis_r)
      2'd0:    mcur = mom_r[0];
      2'd1:    mcur = mom_r[1];
      default: mcur = mom_r[2];
    endcase
    req.start = (state_r == ST_LOAD) ||
                (state_r == ST_DIV && rsp.done && axis_r != 2'd2);
    if (state_r == ST_DIV && rsp.done) begin
      case (axis_r)
        2'd0:    mcur = mom_r[1];
        default: mcur = mom_r[2];
      endcase
    end
    if (state_r == ST_LOAD) mcur = mom_r[0];
    req.neg = mcur[MOM_WIDTH-1];
    req.mag = mcur[MOM_WIDTH-1] ? MOM_WIDTH'(-mcur) : MOM_WIDTH'(mcur);
  end

  pmpa_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .divisor (mass_r),
    .rsp     (rsp)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_nxt = ST_LOAD;
        axis_nxt  = 2'd0;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rsp.done) begin
          if (axis_r == 2'd2) state_nxt = ST_OUT;
          else axis_nxt = axis_r + 2'd1;
        end
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
    if (state_r == ST_DIV && rsp.done) begin
      case (axis_r)
        2'd0:    c_r[0] <= rsp.coord;
        2'd1:    c_r[1] <= rsp.coord;
        default: c_r[2] <= rsp.coord;
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_error      = err_r;
  assign out_total_mass = mass_r;
  assign out_cx         = c_r[0];
  assign out_cy         = c_r[1];
  assign out_cz         = c_r[2];
  assign out_ixx        = diag_r[0];
  assign out_iyy        = diag_r[1];
  assign out_izz        = diag_r[2];
  assign out_ixy        = off_r[0];
  assign out_ixz        = off_r[1];
  assign out_iyz        = off_r[2];

endmodule

/* design/pmpa_checker.sv */
// Port-level checks for the point mass accumulator, bound to the top level.
module pmpa_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_error,
  input logic [pmpa_pkg::MASS_WIDTH-1:0]     out_total_mass,
  input logic signed [pmpa_pkg::COORD_WIDTH-1:0] out_cx
);
  import pmpa_pkg::*;

  // A result beat holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_mass) && $stable(out_error))
    else $error("stalled result changed");

  // No input is taken while a result is offered.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during result");

  // An accepted beat does not show a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // Zero mass gives a zero centroid.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_mass == '0 |-> out_cx == '0)
    else $error("centroid not zero at zero mass");

endmodule

bind point_mass_property_accumulator_core pmpa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_error(out_error),
  .out_total_mass(out_total_mass), .out_cx(out_cx)
);
